// File: design/bor_pkg.sv
`default_nettype none
package bor_pkg;

    localparam int BOR_CACHE_ENTRIES = 64;
    localparam int BOR_KEY_WIDTH     = 32;
    localparam int CAP_WIDTH         = 7;
    localparam int GAP_WIDTH         = 31;
    localparam int NU_WIDTH          = 32;
    localparam int OCC_WIDTH         = 7;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET     = 7'd64;
    localparam logic [NU_WIDTH-1:0]  NU_NEVER      = 32'hFFFF_FFFF;
    localparam logic [NU_WIDTH-1:0]  NU_MAX_FINITE = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_addr;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: design/bor_ctrl.sv
`default_nettype none
module bor_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    output bor_pkg::t_cmd  o_cmd,
    input  bor_pkg::t_sts  i_sts
);
    import bor_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.last_addr) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd     = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.rd = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/bor_datapath.sv
`default_nettype none
module bor_datapath #(
    parameter int CACHE_ENTRIES = bor_pkg::BOR_CACHE_ENTRIES,
    parameter int KEY_WIDTH     = bor_pkg::BOR_KEY_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [KEY_WIDTH-1:0]             i_key,
    input  wire  [bor_pkg::GAP_WIDTH-1:0]    i_gap,
    input  wire                              i_never,
    input  wire                              i_cfg_valid,
    input  wire  [bor_pkg::CAP_WIDTH-1:0]    i_cfg_data,
    input  wire                              i_out_ready,
    input  bor_pkg::t_cmd                    i_cmd,
    output bor_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic                             o_hit,
    output logic                             o_evicted_valid,
    output logic [KEY_WIDTH-1:0]             o_victim_key,
    output logic [bor_pkg::OCC_WIDTH-1:0]    o_occupancy
);
    import bor_pkg::*;

    localparam int AW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW   = $clog2(CACHE_ENTRIES + 1);
    localparam int CMPW = ((CW > CAP_WIDTH) ? CW : CAP_WIDTH) + 1;

    logic [KEY_WIDTH-1:0] mem_key [CACHE_ENTRIES];
    logic [NU_WIDTH-1:0]  mem_nu  [CACHE_ENTRIES];

    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]            r_count;
    logic [NU_WIDTH-1:0]      r_time;
    logic [CAP_WIDTH-1:0]     r_capacity;

    logic [KEY_WIDTH-1:0] r_key;
    logic [NU_WIDTH-1:0]  r_nu;
    logic [AW-1:0]        r_addr;

    logic [KEY_WIDTH-1:0] r_key_q;
    logic [NU_WIDTH-1:0]  r_nu_q;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_rd_vld;

    logic                 r_found;
    logic [AW-1:0]        r_found_idx;
    logic                 r_free_vld;
    logic [AW-1:0]        r_free_idx;
    logic                 r_best_vld;
    logic [AW-1:0]        r_best_idx;
    logic [NU_WIDTH-1:0]  r_best_nu;
    logic [KEY_WIDTH-1:0] r_best_key;

    logic                 r_out_valid;
    logic                 r_o_hit;
    logic                 r_o_ev;
    logic [KEY_WIDTH-1:0] r_o_key;
    logic [OCC_WIDTH-1:0] r_o_occ;

    // Next-use time of the incoming request, saturated below never-again.
    logic [NU_WIDTH:0]   sum_nu;
    logic [NU_WIDTH-1:0] new_nu;
    always_comb begin
        sum_nu = {1'b0, r_time} + {{(NU_WIDTH + 1 - GAP_WIDTH){1'b0}}, i_gap};
        if (i_never) begin
            new_nu = NU_NEVER;
        end else if (sum_nu > {1'b0, NU_MAX_FINITE}) begin
            new_nu = NU_MAX_FINITE;
        end else begin
            new_nu = sum_nu[NU_WIDTH-1:0];
        end
    end

    // Scan of one returned slot.
    logic                s_v;
    logic                s_match;
    logic [NU_WIDTH-1:0] s_nu;
    logic                s_best;
    always_comb begin
        s_v     = r_rd_vld && r_valid[r_rd_idx];
        s_match = s_v && !r_found && (r_key_q == r_key);
        s_nu    = s_match ? r_nu : r_nu_q;
        s_best  = s_v && (!r_best_vld || (s_nu > r_best_nu));
    end

    // Decision at the end of the scan.
    logic              c_ins;
    logic              c_pend;
    logic [CW-1:0]     c_cnt_after;
    logic [CMPW-1:0]   c_cap;
    logic              c_need;
    logic              c_new_wins;
    logic              c_self_ev;
    logic              c_slot_ev;
    logic              c_we;
    logic [AW-1:0]     c_waddr;
    logic              c_wkey;
    logic [CW-1:0]     c_cnt_new;
    always_comb begin
        c_ins       = !r_found && r_free_vld;
        c_pend      = !r_found && !r_free_vld;
        c_cnt_after = r_count + CW'(c_ins);
        if ({1'b0, r_capacity} > CMPW'(CACHE_ENTRIES)) begin
            c_cap = CMPW'(CACHE_ENTRIES);
        end else begin
            c_cap = CMPW'(r_capacity);
        end
        c_need = (CMPW'(c_cnt_after) + CMPW'(c_pend)) > c_cap;
        if (c_ins) begin
            c_new_wins = !r_best_vld || (r_nu > r_best_nu)
                || ((r_nu == r_best_nu) && (r_free_idx < r_best_idx));
        end else if (c_pend) begin
            c_new_wins = !r_best_vld || (r_nu > r_best_nu);
        end else begin
            c_new_wins = 1'b0;
        end
        c_self_ev = c_need && c_new_wins;
        c_slot_ev = c_need && !c_new_wins && r_best_vld;
        c_we      = 1'b0;
        c_wkey    = 1'b0;
        c_waddr   = r_found_idx;
        if (r_found) begin
            c_we = 1'b1;
        end else if (c_ins && !c_self_ev) begin
            c_we    = 1'b1;
            c_wkey  = 1'b1;
            c_waddr = r_free_idx;
        end else if (c_pend && c_slot_ev) begin
            c_we    = 1'b1;
            c_wkey  = 1'b1;
            c_waddr = r_best_idx;
        end
        c_cnt_new = r_count;
        if (c_ins && !c_self_ev) c_cnt_new = c_cnt_after;
        if (c_slot_ev && !c_pend) c_cnt_new = c_cnt_new - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_key_q  <= mem_key[r_addr];
            r_nu_q   <= mem_nu[r_addr];
            r_rd_idx <= r_addr;
        end
        if (i_cmd.commit && c_we) begin
            mem_nu[c_waddr] <= r_nu;
            if (c_wkey) mem_key[c_waddr] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_nu  <= new_nu;
        end
        if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.rd) begin
            r_addr <= r_addr + AW'(1);
        end
        if (s_match) r_found_idx <= r_rd_idx;
        if (s_v == 1'b0 && r_rd_vld && !r_free_vld) r_free_idx <= r_rd_idx;
        if (s_best) begin
            r_best_idx <= r_rd_idx;
            r_best_nu  <= s_nu;
            r_best_key <= r_key_q;
        end
        if (i_cmd.commit) begin
            r_o_hit <= r_found;
            r_o_ev  <= c_self_ev || c_slot_ev;
            r_o_occ <= OCC_WIDTH'(c_cnt_new);
            if (c_self_ev) begin
                r_o_key <= r_key;
            end else if (c_slot_ev) begin
                r_o_key <= r_best_key;
            end else begin
                r_o_key <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_time      <= '0;
            r_capacity  <= CAP_RESET;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_free_vld  <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_capacity <= i_cfg_data;
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_time     <= r_time + NU_WIDTH'(1);
                r_found    <= 1'b0;
                r_free_vld <= 1'b0;
                r_best_vld <= 1'b0;
            end else begin
                if (s_match) r_found <= 1'b1;
                if (r_rd_vld && !s_v) r_free_vld <= 1'b1;
                if (s_best) r_best_vld <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_count <= c_cnt_new;
                if (c_ins && !c_self_ev) r_valid[r_free_idx] <= 1'b1;
                if (c_slot_ev && !c_pend) r_valid[r_best_idx] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last_addr = i_cmd.rd && (r_addr == AW'(CACHE_ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_evicted_valid = r_o_ev;
    assign o_victim_key    = r_o_key;
    assign o_occupancy     = r_o_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CACHE_ENTRIES))
        else $error("resident count beyond table size");
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("resident count disagrees with valid bits");
    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit without a result");
    a_no_commit_over_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit overwrote a pending result");
    a_load_restarts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_addr == '0) && !r_found && !r_best_vld)
        else $error("scan not restarted");

endmodule
`default_nettype wire

// File: design/belady_optimal_replacement.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_object_key, i_next_gap, i_never_again
// out       output     o_out_valid / i_out_ready   o_hit, o_evicted_valid, o_victim_key,
//                                                  o_occupancy
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (capacity)
//
// Each request is accepted, then the single read port of the key and next-use memories
// is swept over every slot in turn, the last read returns, and the update write and the
// result are committed.
// Synchronous active-low reset clears the valid bits, the counters and the capacity
// (back to 64); the memories need no clearing since only valid slots are used.
// A result that has not been taken holds in the output register while the next
// request is scanned; only the commit of that request waits for the output to drain.
`default_nettype none
module belady_optimal_replacement #(
    parameter int CACHE_ENTRIES = bor_pkg::BOR_CACHE_ENTRIES,
    parameter int KEY_WIDTH     = bor_pkg::BOR_KEY_WIDTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [KEY_WIDTH-1:0]            i_object_key,
    input  wire  [bor_pkg::GAP_WIDTH-1:0]   i_next_gap,
    input  wire                             i_never_again,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_hit,
    output logic                            o_evicted_valid,
    output logic [KEY_WIDTH-1:0]            o_victim_key,
    output logic [bor_pkg::OCC_WIDTH-1:0]   o_occupancy,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [bor_pkg::CAP_WIDTH-1:0]   i_cfg_data
);
    import bor_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The capacity register takes a transfer in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences accept, slot sweep, drain and commit.
    bor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The datapath holds the slot table, tracks the matching, free and farthest
    // slots during the sweep, and decides hit, insertion and eviction at commit.
    bor_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .KEY_WIDTH     (KEY_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_key           (i_object_key),
        .i_gap           (i_next_gap),
        .i_never         (i_never_again),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_victim_key    (o_victim_key),
        .o_occupancy     (o_occupancy)
    );

endmodule
`default_nettype wire
